[design/epd_pkg.sv]
// Shared types and constants for the epipolar distance statistics block.
// No dependencies; imported by epd_div and epipolar_distance_stats.
`default_nettype none

package epd_pkg;

  localparam int unsigned MAX_POINTS_DEF = 65536;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned ERR_W   = 24;
  localparam int unsigned OCNT_W  = 17;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned DIVR_W  = 32;  // divisor and partial remainder
  localparam int unsigned QUO_W   = 24;  // quotient bits per division

  localparam logic [ERR_W-1:0] ERR_MAX = '1;

  typedef enum logic [CIDX_W-1:0] {
    CFG_ROW1_AB = 3'd0,
    CFG_C1_A2   = 3'd1,
    CFG_ROW2_BC = 3'd2,
    CFG_ROW3_AB = 3'd3,
    CFG_ROW3_C  = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LINE,
    ST_ABS,
    ST_NORM,
    ST_SIGN,
    ST_PROD,
    ST_SQRT,
    ST_PREP,
    ST_DIV,
    ST_STAT,
    ST_MEAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] left_x;
    logic [COORD_W-1:0] left_y;
    logic [COORD_W-1:0] right_x;
    logic [COORD_W-1:0] right_y;
    logic               last_of_set;
  } in_t;

  typedef struct packed {
    logic [ERR_W-1:0]  point_error;
    logic              line_degenerate;
    logic              set_done;
    logic [ERR_W-1:0]  average_error;
    logic [ERR_W-1:0]  max_error;
    logic [ERR_W-1:0]  min_error;
    logic [OCNT_W-1:0] point_count;
  } out_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

`default_nettype wire

[design/epd_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle while step is asserted.
// Depends on epd_pkg; shared by the point error and the set mean.
`default_nettype none

module epd_div
  import epd_pkg::*;
(
  input  wire logic              clk,
  input  div_ctrl_t              ctrl,
  input  wire logic [DIVR_W-1:0] rem_init,
  input  wire logic [QUO_W-1:0]  low_init,
  input  wire logic [DIVR_W-1:0] divisor,
  output logic      [QUO_W-1:0]  quotient
);

  logic [DIVR_W-1:0] drem;
  logic [QUO_W-1:0]  dlow;
  logic [DIVR_W-1:0] dsr;
  logic [DIVR_W:0]   trial;
  logic              ge;

  assign trial = {drem, dlow[QUO_W-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      drem     <= rem_init;
      dlow     <= low_init;
      dsr      <= divisor;
      quotient <= '0;
    end else if (ctrl.step) begin
      drem     <= ge ? DIVR_W'(trial - {1'b0, dsr}) : trial[DIVR_W-1:0];
      dlow     <= {dlow[QUO_W-2:0], 1'b0};
      quotient <= {quotient[QUO_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

[design/epipolar_distance_stats.sv]
// Sequence: accept, line coefficients, absolute values, normalise, sign restore, products,
// square root, divide prep, divide (no divide when the error saturates), statistics update,
// mean divide on the last beat of a set, output. A degenerate line goes from the absolute
// values straight to the statistics update. One item at a time: no new item is accepted
// until the previous result has been emitted; the output step waits while a held result
// is stalled. Synchronous reset clears control, statistics, F registers.
`default_nettype none

module epipolar_distance_stats
  import epd_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_t                   out_data,
  input  wire logic              cfg_en,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int unsigned SUM_W  = ERR_W + CNT_W;
  localparam int unsigned LINE_W = 50;
  localparam int unsigned MAG_W  = LINE_W - 1;
  localparam int unsigned MUL_W  = 24;
  localparam int unsigned N_W    = 56;
  localparam int unsigned SQ_W   = 49;
  localparam int unsigned RT_W   = 32;
  localparam int unsigned REM_W  = 35;

  state_t state, state_next;

  logic [CFG_W-1:0] f_r1ab, f_c1a2, f_r2bc, f_r3ab;
  logic [31:0]      f_r3c;

  logic [COORD_W-1:0] x1_sh, y1_sh;
  logic [COORD_W-1:0] x2_q, y2_q;
  logic               last_q;
  logic [4:0]         cnt;

  logic signed [LINE_W-1:0] acc_a, acc_b, acc_c;
  logic [MAG_W-1:0]         mag_a, mag_b, mag_c;
  logic                     neg_a, neg_b, neg_c;
  logic signed [MUL_W:0]    a_s, b_s;
  logic [MUL_W-1:0]         xs, ys, as_sh, bs_sh;
  logic signed [N_W-1:0]    n_acc;
  logic [SQ_W-1:0]          sq;
  logic [SQ_W-1:0]          sq_step;
  logic [63:0]              v_sh;
  logic [REM_W-1:0]         srem;
  logic [RT_W-1:0]          root;
  logic                     degen_q, sat_q;
  logic [ERR_W-1:0]         err_q;

  logic [SUM_W-1:0] error_sum;
  logic [CNT_W-1:0] pair_count;
  logic [ERR_W-1:0] running_max, running_min;

  logic [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0] count_next;
  logic [ERR_W-1:0] max_next, min_next, err_now;

  div_ctrl_t         dctl;
  logic [DIVR_W-1:0] d_rem, d_dsr;
  logic [QUO_W-1:0]  d_low, quo;

  logic [N_W-1:0]   num;
  logic             sat_now;
  logic [REM_W-1:0] rem_n, s_trial;
  logic             norm_big;

  logic signed [LINE_W-1:0] ta_a, ta_b, ta_c;
  logic signed [N_W-1:0]    tn_a, tn_b, tn_c;

  epd_div u_div (
    .clk      (clk),
    .ctrl     (dctl),
    .rem_init (d_rem),
    .low_init (d_low),
    .divisor  (d_dsr),
    .quotient (quo)
  );

  // Line coefficients: MSB-first shift-add, the constant term enters at bit four
  always_comb begin
    ta_a = acc_a <<< 1;
    ta_b = acc_b <<< 1;
    ta_c = acc_c <<< 1;
    if (x1_sh[COORD_W-1]) begin
      ta_a = ta_a + LINE_W'($signed(f_r1ab[63:32]));
      ta_b = ta_b + LINE_W'($signed(f_c1a2[31:0]));
      ta_c = ta_c + LINE_W'($signed(f_r3ab[63:32]));
    end
    if (y1_sh[COORD_W-1]) begin
      ta_a = ta_a + LINE_W'($signed(f_r1ab[31:0]));
      ta_b = ta_b + LINE_W'($signed(f_r2bc[63:32]));
      ta_c = ta_c + LINE_W'($signed(f_r3ab[31:0]));
    end
    if (cnt == 5'd4) begin
      ta_a = ta_a + LINE_W'($signed(f_c1a2[63:32]));
      ta_b = ta_b + LINE_W'($signed(f_r2bc[31:0]));
      ta_c = ta_c + LINE_W'($signed(f_r3c));
    end
  end

  always_comb begin
    tn_a = xs[MUL_W-1] ? N_W'(a_s) : '0;
    tn_b = ys[MUL_W-1] ? N_W'(b_s) : '0;
    tn_c = (cnt == 5'd4) ? N_W'(acc_c) : '0;
  end

  assign sq_step  = {sq[SQ_W-2:0], 1'b0}
                  + (as_sh[MUL_W-1] ? SQ_W'(mag_a[MUL_W-1:0]) : '0)
                  + (bs_sh[MUL_W-1] ? SQ_W'(mag_b[MUL_W-1:0]) : '0);
  assign norm_big = (mag_a[MAG_W-1:MUL_W] != '0) || (mag_b[MAG_W-1:MUL_W] != '0);
  assign rem_n    = {srem[REM_W-3:0], v_sh[63:62]};
  assign s_trial  = {1'b0, root, 2'b01};
  assign num      = n_acc[N_W-1] ? N_W'(-n_acc) : N_W'(n_acc);
  assign sat_now  = num >= N_W'({root, 5'b0});

  // Statistics update for the current beat
  always_comb begin
    err_now    = sat_q ? ERR_MAX : quo;
    sum_next   = error_sum;
    count_next = pair_count;
    max_next   = running_max;
    min_next   = running_min;
    if (pair_count < CNT_W'(MAX_POINTS)) begin
      sum_next   = error_sum + SUM_W'(err_now);
      count_next = pair_count + 1'b1;
      if (err_now > running_max) max_next = err_now;
      if (err_now < running_min) min_next = err_now;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    dctl       = '0;
    d_rem      = DIVR_W'(num >> 5);
    d_low      = {num[4:0], 19'b0};
    d_dsr      = root;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = ST_LINE;
      end
      ST_LINE: if (cnt == '0) state_next = ST_ABS;
      ST_ABS: begin
        if (acc_a == '0 && acc_b == '0) state_next = ST_STAT;
        else state_next = ST_NORM;
      end
      ST_NORM: if (!norm_big) state_next = ST_SIGN;
      ST_SIGN: state_next = ST_PROD;
      ST_PROD: if (cnt == '0) state_next = ST_SQRT;
      ST_SQRT: if (cnt == '0) state_next = ST_PREP;
      ST_PREP: begin
        dctl.load  = 1'b1;
        state_next = sat_now ? ST_STAT : ST_DIV;
      end
      ST_DIV: begin
        dctl.step = 1'b1;
        if (cnt == '0) state_next = ST_STAT;
      end
      ST_STAT: begin
        d_rem      = DIVR_W'(sum_next >> ERR_W);
        d_low      = sum_next[ERR_W-1:0];
        d_dsr      = DIVR_W'(count_next);
        dctl.load  = last_q;
        state_next = last_q ? ST_MEAN : ST_EMIT;
      end
      ST_MEAN: begin
        dctl.step = 1'b1;
        if (cnt == '0) state_next = ST_EMIT;
      end
      ST_EMIT: if (!(out_valid && out_stall)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_r1ab <= '0;
      f_c1a2 <= '0;
      f_r2bc <= '0;
      f_r3ab <= '0;
      f_r3c  <= '0;
    end else if (cfg_en) begin
      unique case (cfg_index)
        CFG_ROW1_AB: f_r1ab <= cfg_data;
        CFG_C1_A2:   f_c1a2 <= cfg_data;
        CFG_ROW2_BC: f_r2bc <= cfg_data;
        CFG_ROW3_AB: f_r3ab <= cfg_data;
        CFG_ROW3_C:  f_r3c  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        x1_sh   <= in_data.left_x;
        y1_sh   <= in_data.left_y;
        x2_q    <= in_data.right_x;
        y2_q    <= in_data.right_y;
        last_q  <= in_data.last_of_set;
        acc_a   <= '0;
        acc_b   <= '0;
        acc_c   <= '0;
        degen_q <= 1'b0;
        sat_q   <= 1'b0;
        cnt     <= 5'd15;
      end
      ST_LINE: begin
        acc_a <= ta_a;
        acc_b <= ta_b;
        acc_c <= ta_c;
        x1_sh <= {x1_sh[COORD_W-2:0], 1'b0};
        y1_sh <= {y1_sh[COORD_W-2:0], 1'b0};
        cnt   <= cnt - 1'b1;
      end
      ST_ABS: begin
        neg_a <= acc_a[LINE_W-1];
        neg_b <= acc_b[LINE_W-1];
        neg_c <= acc_c[LINE_W-1];
        mag_a <= acc_a[LINE_W-1] ? MAG_W'(-acc_a) : MAG_W'(acc_a);
        mag_b <= acc_b[LINE_W-1] ? MAG_W'(-acc_b) : MAG_W'(acc_b);
        mag_c <= acc_c[LINE_W-1] ? MAG_W'(-acc_c) : MAG_W'(acc_c);
        if (acc_a == '0 && acc_b == '0) begin
          degen_q <= 1'b1;
          sat_q   <= 1'b1;
        end
      end
      ST_NORM: begin
        // truncate toward zero: shift the magnitudes
        if (norm_big) begin
          mag_a <= mag_a >> 1;
          mag_b <= mag_b >> 1;
          mag_c <= mag_c >> 1;
        end
      end
      ST_SIGN: begin
        a_s   <= neg_a ? -$signed({1'b0, mag_a[MUL_W-1:0]})
                       : $signed({1'b0, mag_a[MUL_W-1:0]});
        b_s   <= neg_b ? -$signed({1'b0, mag_b[MUL_W-1:0]})
                       : $signed({1'b0, mag_b[MUL_W-1:0]});
        acc_c <= neg_c ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
        xs    <= MUL_W'(x2_q);
        ys    <= MUL_W'(y2_q);
        as_sh <= mag_a[MUL_W-1:0];
        bs_sh <= mag_b[MUL_W-1:0];
        n_acc <= '0;
        sq    <= '0;
        cnt   <= 5'd23;
      end
      ST_PROD: begin
        n_acc <= (n_acc <<< 1) + tn_a + tn_b + tn_c;
        sq    <= sq_step;
        xs    <= {xs[MUL_W-2:0], 1'b0};
        ys    <= {ys[MUL_W-2:0], 1'b0};
        as_sh <= {as_sh[MUL_W-2:0], 1'b0};
        bs_sh <= {bs_sh[MUL_W-2:0], 1'b0};
        if (cnt == '0) begin
          cnt  <= 5'd31;
          srem <= '0;
          root <= '0;
          v_sh <= {1'b0, sq_step, 14'b0};
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      ST_SQRT: begin
        // one root bit per cycle, two radicand bits in
        v_sh <= {v_sh[61:0], 2'b00};
        if (rem_n >= s_trial) begin
          srem <= rem_n - s_trial;
          root <= {root[RT_W-2:0], 1'b1};
        end else begin
          srem <= rem_n;
          root <= {root[RT_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end
      ST_PREP: begin
        if (sat_now) sat_q <= 1'b1;
        cnt <= 5'd23;
      end
      ST_DIV:  cnt <= cnt - 1'b1;
      ST_STAT: begin
        err_q <= err_now;
        cnt   <= 5'd23;
      end
      ST_MEAN: cnt <= cnt - 1'b1;
      default: ;
    endcase
  end

  // Statistics and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum   <= '0;
      pair_count  <= '0;
      running_max <= '0;
      running_min <= ERR_MAX;
      out_valid   <= 1'b0;
    end else begin
      if (state == ST_STAT) begin
        error_sum   <= sum_next;
        pair_count  <= count_next;
        running_max <= max_next;
        running_min <= min_next;
      end
      if (state == ST_EMIT && !(out_valid && out_stall)) begin
        out_valid                <= 1'b1;
        out_data.point_error     <= err_q;
        out_data.line_degenerate <= degen_q;
        out_data.set_done        <= last_q;
        out_data.average_error   <= last_q ? quo : '0;
        out_data.max_error       <= last_q ? running_max : '0;
        out_data.min_error       <= last_q ? running_min : '0;
        out_data.point_count     <= last_q ? OCNT_W'(pair_count) : '0;
        if (last_q) begin
          error_sum   <= '0;
          pair_count  <= '0;
          running_max <= '0;
          running_min <= ERR_MAX;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for epipolar_distance_stats: directed table, then random point pairs
// under several fundamental matrices, each result checked against an in-bench predictor
// or a typed-in expectation. Depends on epd_pkg and the epipolar_distance_stats RTL only.
`default_nettype none

module testbench;
  import epd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SET_CAP      = MAX_POINTS_DEF;
  localparam int unsigned SETTLE_CYC   = 200;
  localparam int unsigned HOLD_CYC     = 400;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned RANDOM_PAIRS = 1880;
  localparam int unsigned QUIET_PAIRS  = 150;
  localparam int unsigned MAX_REPORTS  = 60;
  localparam logic [CIDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum int {
    F_KEEP, F_ZERO, F_MAXPOS, F_MAXNEG, F_ONES, F_RANDOM, F_STEREO, F_STEREO_BIG
  } f_mode_t;

  typedef struct {
    f_mode_t fmode;
    in_t     beat;
    bit      typed;
    out_t    want;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_t             out_data;
  logic             cfg_en = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Rides alongside each beat: a typed-in expectation overrides the predictor.
  logic beat_typed = 1'b0;
  out_t beat_want = '0;

  // Shadow registers and running statistics of the predictor
  logic [63:0] f_row1_ab, f_c1_a2, f_row2_bc, f_row3_ab;
  logic [31:0] f_row3_c;
  longint unsigned err_sum;
  int unsigned     pairs_in_set;
  logic [ERR_W-1:0] run_max, run_min;

  out_t pending_results[$];
  int   fail_count = 0;
  int   idle_cycles = 0;
  int   pairs_sent = 0, sets_seen = 0, degen_seen = 0, sat_seen = 0, exact_seen = 0;
  bit   quiet = 1'b0;
  bit   hold_req = 1'b0;

  always #1 clk = ~clk;

  epipolar_distance_stats u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, probe, rem;
    r = 0;
    rem = v;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= r + probe) begin
        rem = rem - (r + probe);
        r = (r >> 1) + probe;
      end else begin
        r = r >> 1;
      end
      probe = probe >> 2;
    end
    return r;
  endfunction

  function automatic longint toward_zero(longint v, int s);
    if (v < 0) return -longint'(longint'(-v) >>> s);
    return v >>> s;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // Line through the left point, distance of the right point, then fold into the set.
  function automatic out_t measure_pair(in_t p);
    longint x1, y1, x2, y2, la, lb, lc, n;
    longint unsigned m, num, r, err;
    int s;
    bit degen;
    out_t o;
    x1 = longint'(p.left_x);
    y1 = longint'(p.left_y);
    x2 = longint'(p.right_x);
    y2 = longint'(p.right_y);
    la = longint'($signed(f_row1_ab[63:32])) * x1 + longint'($signed(f_row1_ab[31:0])) * y1
       + longint'($signed(f_c1_a2[63:32])) * 16;
    lb = longint'($signed(f_c1_a2[31:0])) * x1 + longint'($signed(f_row2_bc[63:32])) * y1
       + longint'($signed(f_row2_bc[31:0])) * 16;
    lc = longint'($signed(f_row3_ab[63:32])) * x1 + longint'($signed(f_row3_ab[31:0])) * y1
       + longint'($signed(f_row3_c)) * 16;
    degen = (la == 0 && lb == 0);
    if (degen) begin
      err = ERR_MAX;
    end else begin
      m = (magnitude(la) > magnitude(lb)) ? magnitude(la) : magnitude(lb);
      s = 0;
      while ((m >> s) >= (64'd1 << 24)) s++;
      la = toward_zero(la, s);
      lb = toward_zero(lb, s);
      lc = toward_zero(lc, s);
      n = la * x2 + lb * y2 + lc * 16;
      num = magnitude(n);
      r = root_floor((longint'(la * la) + longint'(lb * lb)) << 14);
      if (num >= (r << 5)) err = ERR_MAX;
      else err = (num << 19) / r;
      if (err > ERR_MAX) err = ERR_MAX;
    end
    if (pairs_in_set < SET_CAP) begin
      err_sum += err;
      pairs_in_set++;
      if (err > run_max) run_max = err[ERR_W-1:0];
      if (err < run_min) run_min = err[ERR_W-1:0];
    end
    o = '0;
    o.point_error = err[ERR_W-1:0];
    o.line_degenerate = degen;
    o.set_done = p.last_of_set;
    if (p.last_of_set) begin
      o.average_error = ERR_W'(err_sum / pairs_in_set);
      o.max_error = run_max;
      o.min_error = run_min;
      o.point_count = OCNT_W'(pairs_in_set);
      err_sum = 0;
      pairs_in_set = 0;
      run_max = '0;
      run_min = ERR_MAX;
    end
    return o;
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // Predict on every accepted input beat, check every accepted result beat.
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      f_row1_ab = '0; f_c1_a2 = '0; f_row2_bc = '0; f_row3_ab = '0; f_row3_c = '0;
      err_sum = 0; pairs_in_set = 0; run_max = '0; run_min = ERR_MAX;
      pending_results.delete();
    end else begin
      idle_cycles++;
      if (cfg_en) begin
        case (cfg_index)
          CFG_ROW1_AB: f_row1_ab = cfg_data;
          CFG_C1_A2:   f_c1_a2 = cfg_data;
          CFG_ROW2_BC: f_row2_bc = cfg_data;
          CFG_ROW3_AB: f_row3_ab = cfg_data;
          CFG_ROW3_C:  f_row3_c = cfg_data[31:0];
          default: ;
        endcase
        idle_cycles = 0;
      end
      if (in_valid && !in_stall) begin
        want = measure_pair(in_data);
        pending_results.insert(pending_results.size(), beat_typed ? beat_want : want);
        idle_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat, expected none actual %0h", $time, out_data);
        end else begin
          want = pending_results.pop_front();
          check_field("point_error", want.point_error, out_data.point_error);
          check_field("line_degenerate", want.line_degenerate, out_data.line_degenerate);
          check_field("set_done", want.set_done, out_data.set_done);
          check_field("average_error", want.average_error, out_data.average_error);
          check_field("max_error", want.max_error, out_data.max_error);
          check_field("min_error", want.min_error, out_data.min_error);
          check_field("point_count", want.point_count, out_data.point_count);
          if (out_data.set_done) sets_seen++;
          if (out_data.line_degenerate) degen_seen++;
          if (out_data.point_error == ERR_MAX) sat_seen++;
          if (out_data.point_error == '0) exact_seen++;
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, one long hold on request, none when quiet.
  initial begin
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic offer_pair(in_t d, bit typed, out_t want);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    beat_typed <= typed;
    beat_want <= want;
    do @(posedge clk); while (in_stall);
    pairs_sent++;
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // Drain the block, then load a whole matrix. Spare indexes must be ignored.
  task automatic load_matrix(f_mode_t fmode);
    logic [31:0] f[9];
    logic [31:0] k;
    if (fmode == F_KEEP) return;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    for (int i = 0; i < 9; i++) begin
      case (fmode)
        F_ZERO:   f[i] = '0;
        F_MAXPOS: f[i] = 32'h7FFF_FFFF;
        F_MAXNEG: f[i] = 32'h8000_0000;
        F_ONES:   f[i] = '1;
        F_RANDOM: f[i] = $urandom;
        default:  f[i] = 32'($signed($urandom_range(0, 64)) - 32);
      endcase
    end
    if (fmode == F_STEREO || fmode == F_STEREO_BIG) begin
      // pure horizontal baseline: line is right_y = left_y, plus a little skew
      k = (fmode == F_STEREO_BIG) ? 32'h4000_0000 : 32'($urandom_range(1, 1 << 20));
      f[4] = '0; f[6] = '0; f[8] = '0;
      f[5] = -k;
      f[7] = k;
    end
    write_reg(CFG_ROW1_AB, {f[0], f[1]});
    write_reg(CFG_C1_A2, {f[2], f[3]});
    write_reg(CFG_ROW2_BC, {f[4], f[5]});
    write_reg(CFG_ROW3_AB, {f[6], f[7]});
    write_reg(CFG_ROW3_C, {$urandom, f[8]});
    write_reg(CIDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), {$urandom, $urandom});
    cfg_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_t pair_of(int lx, int ly, int rx, int ry, bit last);
    in_t p;
    p.left_x = COORD_W'(lx);
    p.left_y = COORD_W'(ly);
    p.right_x = COORD_W'(rx);
    p.right_y = COORD_W'(ry);
    p.last_of_set = last;
    return p;
  endfunction

  function automatic out_t degen_result(bit last, int cnt);
    out_t o;
    o = '0;
    o.point_error = ERR_MAX;
    o.line_degenerate = 1'b1;
    o.set_done = last;
    if (last) begin
      o.average_error = ERR_MAX;
      o.max_error = ERR_MAX;
      o.min_error = ERR_MAX;
      o.point_count = OCNT_W'(cnt);
    end
    return o;
  endfunction

  initial begin
    dir_row_t dir_rows[$];
    f_mode_t fmode;
    in_t p;
    int dy;
    int ry;

    // All-zero matrix after reset: every line is degenerate.
    dir_rows.insert(dir_rows.size(),
                    '{F_KEEP, pair_of(0, 0, 0, 0, 0), 1, degen_result(0, 0)});
    dir_rows.insert(dir_rows.size(),
                    '{F_KEEP, pair_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0), 1,
                      degen_result(0, 0)});
    dir_rows.insert(dir_rows.size(),
                    '{F_KEEP, pair_of(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 0), 1,
                      degen_result(0, 0)});
    dir_rows.insert(dir_rows.size(),
                    '{F_KEEP, pair_of(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1), 1,
                      degen_result(1, 4)});
    dir_rows.insert(dir_rows.size(),
                    '{F_KEEP, pair_of(1, 2, 3, 4, 1), 1, degen_result(1, 1)});
    // Horizontal baseline: point on the line, far off it, and the coordinate extremes.
    dir_rows.insert(dir_rows.size(),
                    '{F_STEREO_BIG, pair_of(100, 200, 300, 200, 0), 0, '0});
    dir_rows.insert(dir_rows.size(), '{F_KEEP, pair_of(100, 200, 300, 216, 0), 0, '0});
    dir_rows.insert(dir_rows.size(),
                    '{F_KEEP, pair_of(0, 0, 16'hFFFF, 16'hFFFF, 0), 0, '0});
    dir_rows.insert(dir_rows.size(),
                    '{F_KEEP, pair_of(16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 1), 0, '0});
    dir_rows.insert(dir_rows.size(),
                    '{F_STEREO, pair_of(1234, 4321, 999, 4330, 1), 0, '0});
    // Matrix entries at their extremes: large coefficients, shifted down.
    dir_rows.insert(dir_rows.size(),
                    '{F_MAXPOS, pair_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0), 0, '0});
    dir_rows.insert(dir_rows.size(), '{F_KEEP, pair_of(0, 0, 0, 0, 1), 0, '0});
    dir_rows.insert(dir_rows.size(),
                    '{F_MAXNEG, pair_of(16'hFFFF, 0, 0, 16'hFFFF, 0), 0, '0});
    dir_rows.insert(dir_rows.size(),
                    '{F_KEEP, pair_of(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1), 0, '0});
    dir_rows.insert(dir_rows.size(),
                    '{F_ONES, pair_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0), 0, '0});
    dir_rows.insert(dir_rows.size(), '{F_KEEP, pair_of(7, 9, 11, 13, 1), 0, '0});
    dir_rows.insert(dir_rows.size(),
                    '{F_RANDOM, pair_of(16'h1234, 16'h4321, 16'h0FF0, 16'hF00F, 1), 0, '0});

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      load_matrix(dir_rows[i].fmode);
      offer_pair(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random part: mostly realistic geometry so errors stay in range, some wild matrices.
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i % 150 == 0) begin
        case ($urandom_range(0, 9))
          0:       fmode = F_RANDOM;
          1:       fmode = F_MAXPOS;
          2:       fmode = F_MAXNEG;
          3:       fmode = F_ONES;
          4:       fmode = F_ZERO;
          5:       fmode = F_STEREO_BIG;
          default: fmode = F_STEREO;
        endcase
        load_matrix(fmode);
        if (i == 150) hold_req = 1'b1;
      end
      if (i == RANDOM_PAIRS - QUIET_PAIRS) quiet = 1'b1;
      p = {$urandom, $urandom, 1'b0};
      p.last_of_set = ($urandom_range(0, 7) == 0) || (i == RANDOM_PAIRS - 1);
      if ($urandom_range(0, 9) < 7) begin
        dy = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 8000)) - 4000;
        ry = int'(p.left_y) + dy;
        if (ry < 0) ry = 0;
        if (ry > 16'hFFFF) ry = 16'hFFFF;
        p.right_y = COORD_W'(ry);
      end
      offer_pair(p, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    $display("Sent %0d point pairs over %0d finished sets; %0d degenerate, %0d saturated,",
             pairs_sent, sets_seen, degen_seen, sat_seen);
    $display("%0d exact hits, under extreme, random and baseline-style matrices.", exact_seen);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
design/epd_pkg.sv
design/epd_div.sv
design/epipolar_distance_stats.sv
dv/testbench.sv
